// File: src/pce_pkg.sv
// Shared types and constants for the pixel color effect blend block.
package pce_pkg;

    localparam int CH_W    = 6;
    localparam int N_CH    = 3;
    localparam int COLOR_W = CH_W * N_CH;
    localparam int ALPHA_W = 5;
    localparam int WEIGHT_W = 5;
    localparam int MODE_W  = 2;
    localparam int CFG_W   = 5;
    localparam int COEF_W  = 6;
    localparam int PROD_W  = 2 * CH_W;
    localparam int COEF_MAX = 32;
    localparam int CH_MAX   = 63;
    localparam int ROUND    = 16;
    localparam int FRAC_W   = 5;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE     = 2'd0,
        CFG_TOP_W    = 2'd1,
        CFG_BOT_W    = 2'd2,
        CFG_BRIGHT_W = 2'd3
    } t_cfg_idx;

    // Programmed effect mode
    typedef enum logic [MODE_W-1:0] {
        MODE_NONE   = 2'd0,
        MODE_BLEND  = 2'd1,
        MODE_BRIGHT = 2'd2,
        MODE_DARK   = 2'd3
    } t_mode;

    // Effect actually applied to a pixel
    typedef enum logic [1:0] {
        OP_PASS   = 2'd0,
        OP_BLEND  = 2'd1,
        OP_BRIGHT = 2'd2,
        OP_DARK   = 2'd3
    } t_op;

    // Per-pixel control handed from the selector to the channel units
    typedef struct packed {
        t_op                op;
        logic [COEF_W-1:0]  af;
        logic [COEF_W-1:0]  bf;
        logic [COEF_W-1:0]  y;
    } t_ctrl;

    // Captured input pixel
    typedef struct packed {
        logic [COLOR_W-1:0] top_color;
        logic [ALPHA_W-1:0] top_alpha;
        logic               top_is_first_target;
        logic               top_force_alpha;
        logic [COLOR_W-1:0] bottom_color;
        logic               bottom_is_second_target;
        logic               effects_allowed;
    } t_pix_in;

    // Coefficient as min(32, 2*c)
    function automatic logic [COEF_W-1:0] coef(input logic [WEIGHT_W-1:0] c);
        logic [COEF_W-1:0] d;
        d = {c, 1'b0};
        coef = (d > COEF_W'(COEF_MAX)) ? COEF_W'(COEF_MAX) : d;
    endfunction

endpackage

// File: src/pce_in_if.sv
// Input pixel channel: valid/ready handshake and pixel fields.
interface pce_in_if;
    logic                         valid;
    logic                         ready;
    logic [pce_pkg::COLOR_W-1:0]  top_color;
    logic [pce_pkg::ALPHA_W-1:0]  top_alpha;
    logic                         top_is_first_target;
    logic                         top_force_alpha;
    logic [pce_pkg::COLOR_W-1:0]  bottom_color;
    logic                         bottom_is_second_target;
    logic                         effects_allowed;

    modport source (
        output valid, top_color, top_alpha, top_is_first_target, top_force_alpha,
               bottom_color, bottom_is_second_target, effects_allowed,
        input  ready
    );
    modport sink (
        input  valid, top_color, top_alpha, top_is_first_target, top_force_alpha,
               bottom_color, bottom_is_second_target, effects_allowed,
        output ready
    );
endinterface

// File: src/pce_out_if.sv
// Output pixel channel: valid/ready handshake and result color.
interface pce_out_if;
    logic                         valid;
    logic                         ready;
    logic [pce_pkg::COLOR_W-1:0]  pixel_color;

    modport source (output valid, pixel_color, input ready);
    modport sink   (input valid, pixel_color, output ready);
endinterface

// File: src/pce_ctrl.sv
// Effect selection and coefficient setup for one pixel.
module pce_ctrl (
    input  pce_pkg::t_pix_in               i_pix,
    input  pce_pkg::t_mode                 i_mode,
    input  logic [pce_pkg::WEIGHT_W-1:0]   i_top_weight,
    input  logic [pce_pkg::WEIGHT_W-1:0]   i_bot_weight,
    input  logic [pce_pkg::WEIGHT_W-1:0]   i_bright_weight,
    output pce_pkg::t_ctrl                 o_ctrl
);
    logic            can_shade;
    logic            can_blend;
    logic            forced;
    pce_pkg::t_mode  mode;

    assign can_shade = i_pix.top_is_first_target;
    assign can_blend = (i_pix.top_is_first_target | i_pix.top_force_alpha)
                     & i_pix.bottom_is_second_target;
    assign forced    = i_pix.top_force_alpha & i_pix.bottom_is_second_target;
    assign mode      = forced ? pce_pkg::MODE_BLEND : i_mode;

    always_comb begin
        // Pick the effect that applies to this pixel
        o_ctrl.op = pce_pkg::OP_PASS;
        if (i_pix.effects_allowed) begin
            case (mode)
                pce_pkg::MODE_BLEND:  o_ctrl.op = can_blend ? pce_pkg::OP_BLEND  : pce_pkg::OP_PASS;
                pce_pkg::MODE_BRIGHT: o_ctrl.op = can_shade ? pce_pkg::OP_BRIGHT : pce_pkg::OP_PASS;
                pce_pkg::MODE_DARK:   o_ctrl.op = can_shade ? pce_pkg::OP_DARK   : pce_pkg::OP_PASS;
                default:              o_ctrl.op = pce_pkg::OP_PASS;
            endcase
        end

        // Blend weights: 3D alpha overrides the programmed coefficients
        o_ctrl.y = pce_pkg::coef(i_bright_weight);
        if (forced && (i_pix.top_alpha != '0)) begin
            o_ctrl.af = pce_pkg::COEF_W'(i_pix.top_alpha) + pce_pkg::COEF_W'(1);
            o_ctrl.bf = pce_pkg::COEF_W'(pce_pkg::COEF_MAX) - o_ctrl.af;
        end else begin
            o_ctrl.af = pce_pkg::coef(i_top_weight);
            o_ctrl.bf = pce_pkg::coef(i_bot_weight);
        end
    end
endmodule

// File: src/pce_chan.sv
// Per-channel weighted sum with rounding and saturation.
module pce_chan (
    input  pce_pkg::t_ctrl                i_ctrl,
    input  logic [pce_pkg::CH_W-1:0]      i_top,
    input  logic [pce_pkg::CH_W-1:0]      i_bot,
    output logic [pce_pkg::CH_W-1:0]      o_ch
);
    localparam int QUO_W = pce_pkg::PROD_W - pce_pkg::FRAC_W;

    logic [pce_pkg::COEF_W-1:0]  mul_a;
    logic [pce_pkg::COEF_W-1:0]  mul_b;
    logic [pce_pkg::CH_W-1:0]    opnd_b;
    logic [pce_pkg::PROD_W-1:0]  prod_a;
    logic [pce_pkg::PROD_W-1:0]  prod_b;
    logic [pce_pkg::PROD_W-1:0]  sum;
    logic [QUO_W-1:0]            quo;

    // Map all effects onto t*A + B*C: brighten uses 63 as the second operand
    always_comb begin
        mul_a  = pce_pkg::COEF_W'(pce_pkg::COEF_MAX) - i_ctrl.y;
        mul_b  = '0;
        opnd_b = '0;
        case (i_ctrl.op)
            pce_pkg::OP_BLEND: begin
                mul_a  = i_ctrl.af;
                mul_b  = i_ctrl.bf;
                opnd_b = i_bot;
            end
            pce_pkg::OP_BRIGHT: begin
                mul_b  = i_ctrl.y;
                opnd_b = pce_pkg::CH_W'(pce_pkg::CH_MAX);
            end
            default: begin
                mul_b  = '0;
                opnd_b = '0;
            end
        endcase
    end

    assign prod_a = i_top * mul_a;
    assign prod_b = opnd_b * mul_b;
    assign sum    = prod_a + prod_b + pce_pkg::PROD_W'(pce_pkg::ROUND);
    assign quo    = sum[pce_pkg::PROD_W-1:pce_pkg::FRAC_W];

    // Saturate, or pass the top channel through
    always_comb begin
        if (i_ctrl.op == pce_pkg::OP_PASS) begin
            o_ch = i_top;
        end else if (quo > QUO_W'(pce_pkg::CH_MAX)) begin
            o_ch = pce_pkg::CH_W'(pce_pkg::CH_MAX);
        end else begin
            o_ch = quo[pce_pkg::CH_W-1:0];
        end
    end
endmodule

// File: src/pixel_color_effect_blend_top.sv
// Top level of the pixel color effect blend block.
//
// Usage:
//   Pixels enter on i_pix (valid/ready) with top and bottom colors, target
//   flags, the 3D alpha and the window enable. One color per pixel leaves
//   on o_pix (valid/ready), in order.
//   Effect mode and the three weights are written through i_cfg_we,
//   i_cfg_idx and i_cfg_data while no pixel is in flight.
//   An accepted pixel is captured in the input register; its color is
//   loaded into the output register once that register is free, and
//   shown from then on. Throughput: one pixel per cycle unless the receiver
//   stalls; the arithmetic between the two registers is a selector and two
//   6x6 multiplies per channel. Reset clears the configuration registers
//   to zero (no effect) and empties both stages.
//   When the receiver stalls, the output register holds its color and the
//   input register still takes a pixel if it is free; i_pix.ready drops
//   only when both stages are full and the output is not taken.
module pixel_color_effect_blend_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [1:0]                     i_cfg_idx,
    input  logic [pce_pkg::CFG_W-1:0]      i_cfg_data,
    pce_in_if.sink                         i_pix,
    pce_out_if.source                      o_pix
);
    pce_pkg::t_mode                 r_mode;
    logic [pce_pkg::WEIGHT_W-1:0]   r_top_weight;
    logic [pce_pkg::WEIGHT_W-1:0]   r_bot_weight;
    logic [pce_pkg::WEIGHT_W-1:0]   r_bright_weight;
    logic                           r_s1_v;
    pce_pkg::t_pix_in               r_s1;
    logic                           r_out_v;
    logic [pce_pkg::COLOR_W-1:0]    r_out_color;
    logic [pce_pkg::COLOR_W-1:0]    n_out_color;
    logic                           out_adv;
    logic                           s1_adv;
    pce_pkg::t_ctrl                 ctrl;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= pce_pkg::MODE_NONE;
            r_top_weight    <= '0;
            r_bot_weight    <= '0;
            r_bright_weight <= '0;
        end else if (i_cfg_we) begin
            case (pce_pkg::t_cfg_idx'(i_cfg_idx))
                pce_pkg::CFG_MODE:     r_mode <= pce_pkg::t_mode'(i_cfg_data[pce_pkg::MODE_W-1:0]);
                pce_pkg::CFG_TOP_W:    r_top_weight    <= i_cfg_data[pce_pkg::WEIGHT_W-1:0];
                pce_pkg::CFG_BOT_W:    r_bot_weight    <= i_cfg_data[pce_pkg::WEIGHT_W-1:0];
                pce_pkg::CFG_BRIGHT_W: r_bright_weight <= i_cfg_data[pce_pkg::WEIGHT_W-1:0];
                default:               r_mode <= r_mode;
            endcase
        end
    end

    // Stage handshake: each register advances when the one after it is free
    assign out_adv     = !r_out_v || o_pix.ready;
    assign s1_adv      = !r_s1_v || out_adv;
    assign i_pix.ready = s1_adv;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_adv) begin
            r_s1_v <= i_pix.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && i_pix.valid) begin
            r_s1.top_color               <= i_pix.top_color;
            r_s1.top_alpha               <= i_pix.top_alpha;
            r_s1.top_is_first_target     <= i_pix.top_is_first_target;
            r_s1.top_force_alpha         <= i_pix.top_force_alpha;
            r_s1.bottom_color            <= i_pix.bottom_color;
            r_s1.bottom_is_second_target <= i_pix.bottom_is_second_target;
            r_s1.effects_allowed         <= i_pix.effects_allowed;
        end
    end

    // Effect selection
    pce_ctrl u_ctrl (
        .i_pix           (r_s1),
        .i_mode          (r_mode),
        .i_top_weight    (r_top_weight),
        .i_bot_weight    (r_bot_weight),
        .i_bright_weight (r_bright_weight),
        .o_ctrl          (ctrl)
    );

    // One arithmetic unit per color channel
    for (genvar g = 0; g < pce_pkg::N_CH; g++) begin : g_chan
        pce_chan u_chan (
            .i_ctrl (ctrl),
            .i_top  (r_s1.top_color[g*pce_pkg::CH_W +: pce_pkg::CH_W]),
            .i_bot  (r_s1.bottom_color[g*pce_pkg::CH_W +: pce_pkg::CH_W]),
            .o_ch   (n_out_color[g*pce_pkg::CH_W +: pce_pkg::CH_W])
        );
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_adv) begin
            r_out_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_v) begin
            r_out_color <= n_out_color;
        end
    end

    assign o_pix.valid       = r_out_v;
    assign o_pix.pixel_color = r_out_color;

    // A pending pixel in the input register always fills the output register when it advances
    a_out_from_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_s1_v) |=> r_out_v)
        else $error("output register did not load a pending pixel");

    // Pixels outside the effect window leave unchanged
    a_window_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_adv && r_s1_v && !r_s1.effects_allowed)
            |=> (r_out_color == $past(r_s1.top_color)))
        else $error("pixel outside effect window was modified");

    // A full, stalled pipeline refuses input
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_v && r_out_v && !o_pix.ready) |-> !i_pix.ready)
        else $error("input accepted while both stages were full");

    // Mode write lands in the mode register
    a_cfg_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_we && (i_cfg_idx == pce_pkg::CFG_MODE))
            |=> (r_mode == pce_pkg::t_mode'($past(i_cfg_data[pce_pkg::MODE_W-1:0]))))
        else $error("effect mode write lost");
endmodule
